// ===== src/sfd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfd_pkg: shared types for the serial frame deframer
// Phase encoding and the result record carried through the output queue.
// ----------------------------------------------------------------------------
package sfd_pkg;

	typedef enum logic [2:0] {
		PH_HUNT    = 3'd0,
		PH_SPARE   = 3'd1,
		PH_SIZE_LO = 3'd2,
		PH_SIZE_HI = 3'd3,
		PH_PAYLOAD = 3'd4
	} phase_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       has_data;
		logic       last;
		logic       escape_error;
		logic       length_error;
	} res_t;

	// wire bytes of header counted in the size field
	localparam logic [15:0] HDR_BYTES = 16'd4;

	localparam res_t RES_NONE = '{default: '0};

endpackage

// ===== src/serial_frame_deframer_unstuff.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// serial_frame_deframer_unstuff: start-byte deframer with escape removal
// Hunts for frames, reads the size field and emits unstuffed payload bytes.
// ----------------------------------------------------------------------------
// Usage:
//  - s_axis carries one received serial byte per request (tdata = rx_byte).
//  - m_axis carries results: tdata = data_byte, tlast = last of a message,
//    tuser = {length_error, escape_error, has_data}. A status-only result
//    (empty payload or bad size) has has_data = 0 and tdata = 0.
//  - cfg_we / cfg_wdata write start_byte; write only while the block is idle.
//  - Results are written into the queue as their byte is accepted; m_axis shows its head.
//  - Throughput: one byte per cycle while s_axis_tready is high. A byte may
//    give two results (a lone start byte followed by another byte); the
//    four-entry result queue absorbs this, and s_axis_tready drops only while
//    three or more results are queued, so the queue depth sets the stall behavior.
//  - When the receiver stalls, results stack in the queue and s_axis_tready
//    falls once fewer than two slots remain; nothing is dropped.
//  - Reset (arst_n low) empties the queue, returns to start-byte hunt and
//    sets start_byte to 0x7E.
// ----------------------------------------------------------------------------
module serial_frame_deframer_unstuff (
	input  logic       clk,
	input  logic       arst_n,
	// config
	input  logic       cfg_we,
	input  logic [7:0] cfg_wdata,      // start_byte
	// byte stream in
	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,   // [7:0] rx_byte
	// result stream out
	output logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	output logic [7:0] m_axis_tdata,   // [7:0] data_byte
	output logic       m_axis_tlast,   // last
	output logic [2:0] m_axis_tuser    // [0] has_data, [1] escape_error, [2] length_error
);
	import sfd_pkg::*;

	// ---------------- state ----------------
	logic [7:0]  start_byte_q;
	phase_t      phase_q, phase_d;
	logic [7:0]  size_low_q, size_low_d;
	logic [15:0] bytes_left_q, bytes_left_d;
	logic        pending_q, pending_d;

	// result queue: 4 entries
	res_t        fifo_q [4];
	logic [1:0]  wr_ptr_q, rd_ptr_q;
	logic [2:0]  count_q;

	logic        in_acc, out_acc;
	logic [7:0]  b;
	logic        is_start;
	logic [15:0] size_w;
	logic [15:0] left_dec;
	logic        done;

	res_t        res0, res1;
	logic [1:0]  nres;

	assign b        = s_axis_tdata;
	assign is_start = (b == start_byte_q);
	assign size_w   = {b, size_low_q};
	// payload countdown: the current byte is one of the remaining wire bytes
	assign left_dec = (bytes_left_q != 16'd0) ? bytes_left_q - 16'd1 : bytes_left_q;
	assign done     = (left_dec == 16'd0);

	assign s_axis_tready = (count_q < 3'd3);
	assign in_acc        = s_axis_tvalid && s_axis_tready;
	assign m_axis_tvalid = (count_q != 3'd0);
	assign out_acc       = m_axis_tvalid && m_axis_tready;

	// ---------------- next state ----------------
	always_comb begin
		phase_d      = phase_q;
		size_low_d   = size_low_q;
		bytes_left_d = bytes_left_q;
		pending_d    = pending_q;
		case (phase_q)
			PH_SPARE: begin
				phase_d = PH_SIZE_LO;
			end
			PH_SIZE_LO: begin
				size_low_d = b;
				phase_d    = PH_SIZE_HI;
			end
			PH_SIZE_HI: begin
				if (size_w <= HDR_BYTES) begin
					phase_d = PH_HUNT;
				end else begin
					bytes_left_d = size_w - HDR_BYTES;
					pending_d    = 1'b0;
					phase_d      = PH_PAYLOAD;
				end
			end
			PH_PAYLOAD: begin
				bytes_left_d = left_dec;
				// a start byte closes a pending pair, else opens one unless it is the end
				pending_d    = !pending_q && is_start && !done;
				phase_d = done ? PH_HUNT : PH_PAYLOAD;
			end
			default: begin
				pending_d = 1'b0;
				phase_d   = is_start ? PH_SPARE : PH_HUNT;
			end
		endcase
	end

	// ---------------- results ----------------
	always_comb begin
		res0 = RES_NONE;
		res1 = RES_NONE;
		nres = 2'd0;
		case (phase_q)
			PH_SIZE_HI: begin
				if (size_w < HDR_BYTES) begin
					res0.last         = 1'b1;
					res0.length_error = 1'b1;
					nres              = 2'd1;
				end else if (size_w == HDR_BYTES) begin
					res0.last = 1'b1;
					nres      = 2'd1;
				end
			end
			PH_PAYLOAD: begin
				if (pending_q && is_start) begin
					// doubled start byte gives one data byte
					res0 = '{data_byte: b, has_data: 1'b1, last: done,
					         escape_error: 1'b0, length_error: 1'b0};
					nres = 2'd1;
				end else begin
					if (pending_q) begin
						// lone start byte, flagged; current byte follows
						res0 = '{data_byte: start_byte_q, has_data: 1'b1, last: 1'b0,
						         escape_error: 1'b1, length_error: 1'b0};
					end
					if (is_start) begin
						if (done) begin
							res1 = '{data_byte: b, has_data: 1'b1, last: 1'b1,
							         escape_error: 1'b1, length_error: 1'b0};
						end
					end else begin
						res1 = '{data_byte: b, has_data: 1'b1, last: done,
						         escape_error: 1'b0, length_error: 1'b0};
					end
					if (pending_q) begin
						nres = (!is_start || done) ? 2'd2 : 2'd1;
					end else begin
						res0 = res1;
						nres = (!is_start || done) ? 2'd1 : 2'd0;
					end
				end
			end
			default: begin
				nres = 2'd0;
			end
		endcase
	end

	// ---------------- registers ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_byte_q <= 8'd126;
			phase_q      <= PH_HUNT;
			size_low_q   <= 8'd0;
			bytes_left_q <= 16'd0;
			pending_q    <= 1'b0;
			wr_ptr_q     <= 2'd0;
			rd_ptr_q     <= 2'd0;
			count_q      <= 3'd0;
		end else begin
			if (cfg_we) begin
				start_byte_q <= cfg_wdata;
			end
			if (in_acc) begin
				phase_q      <= phase_d;
				size_low_q   <= size_low_d;
				bytes_left_q <= bytes_left_d;
				pending_q    <= pending_d;
				wr_ptr_q     <= wr_ptr_q + nres;
			end
			if (out_acc) begin
				rd_ptr_q <= rd_ptr_q + 2'd1;
			end
			count_q <= count_q + (in_acc ? {1'b0, nres} : 3'd0) - {2'b0, out_acc};
		end
	end

	// queue payload, no reset
	always_ff @(posedge clk) begin
		if (in_acc && nres != 2'd0) begin
			fifo_q[wr_ptr_q] <= res0;
		end
		if (in_acc && nres == 2'd2) begin
			fifo_q[wr_ptr_q + 2'd1] <= res1;
		end
	end

	res_t head;
	assign head          = fifo_q[rd_ptr_q];
	assign m_axis_tdata  = head.data_byte;
	assign m_axis_tlast  = head.last;
	assign m_axis_tuser  = {head.length_error, head.escape_error, head.has_data};

`ifndef NO_ASSERTIONS
	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= 3'd4)
		else $error("result queue overflow");

	a_payload_left: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_PAYLOAD |-> bytes_left_q != 16'd0)
		else $error("payload phase with no bytes left");

	a_len_err: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[2] |-> m_axis_tlast && !m_axis_tuser[0])
		else $error("length error not a final status result");

	a_esc_err: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tuser[0] && !m_axis_tuser[2])
		else $error("escape error without data");

	a_no_data_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata == 8'd0 && m_axis_tlast)
		else $error("status result carries data");
`endif

endmodule
